// File: src/min_tracking_stack_core_macros.svh
// ----------------------------------------------------------------------------
// min tracking stack assertion macros
// Concurrent assertion helpers shared by the stack RTL.
// ----------------------------------------------------------------------------
`ifndef MIN_TRACKING_STACK_CORE_MACROS_SVH
`define MIN_TRACKING_STACK_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define MTS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("stack assertion failed");

// next-cycle implication, checked out of reset
`define MTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("stack assertion failed");

`else

`define MTS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define MTS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: src/mts_pkg.sv
// ----------------------------------------------------------------------------
// min tracking stack package
// Sizes, codes and structs shared by the stack modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mts_pkg;

    // stack geometry
    localparam int STACK_DEPTH = 256;
    localparam int WORD_W      = 32;
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // operation codes
    typedef enum logic {
        KIND_PUSH = 1'b0,
        KIND_POP  = 1'b1
    } t_kind;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    // one memory port request
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [WORD_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } t_mem_req;

    // finished result from the controller
    typedef struct packed {
        logic              valid;
        t_status           status;
        logic [WORD_W-1:0] popped;
        logic [WORD_W-1:0] cur_min;
        logic              min_valid;
        logic [CNT_W-1:0]  depth;
    } t_result;

endpackage

`default_nettype wire

// File: src/mts_in_if.sv
// ----------------------------------------------------------------------------
// min tracking stack channels
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mts_in_if import mts_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [WORD_W-1:0] push_value;

    modport source (output valid, output kind, output push_value, input ready);
    modport sink   (input valid, input kind, input push_value, output ready);
endinterface

interface mts_out_if import mts_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [WORD_W-1:0] popped_value;
    logic [WORD_W-1:0] current_min;
    logic              min_valid;
    logic [CNT_W-1:0]  depth;

    modport source (output valid, output status, output popped_value,
                    output current_min, output min_valid, output depth, input ready);
    modport sink   (input valid, input status, input popped_value,
                    input current_min, input min_valid, input depth, output ready);
endinterface

`default_nettype wire

// File: src/mts_ram.sv
// ----------------------------------------------------------------------------
// generic synchronous RAM
// One write port, one read port with registered read data held between reads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: src/mts_ctrl.sv
// ----------------------------------------------------------------------------
// min tracking stack controller
// Counters and sequencer: reads the top entries, updates both stacks, builds
// the result of each transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "min_tracking_stack_core_macros.svh"

module mts_ctrl import mts_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    mts_in_if.sink                 i_in,
    input  wire logic [WORD_W-1:0] i_val_rdata,
    input  wire logic [WORD_W-1:0] i_min_rdata,
    input  wire logic              i_out_free,
    output t_mem_req               o_val_req,
    output t_mem_req               o_min_req,
    output t_result                o_res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FIX
    } t_state;

    t_state            r_state,   n_state;
    logic [CNT_W-1:0]  r_val_cnt, n_val_cnt;
    logic [CNT_W-1:0]  r_min_cnt, n_min_cnt;
    logic              r_kind,    n_kind;
    logic [WORD_W-1:0] r_word,    n_word;
    logic [WORD_W-1:0] r_popped,  n_popped;

    logic              accept;
    logic [CNT_W-1:0]  val_cnt_m1;
    logic [CNT_W-1:0]  min_cnt_m1;
    logic [CNT_W-1:0]  min_cnt_m2;
    logic              stack_full;
    logic              min_push;

    assign accept     = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign val_cnt_m1 = r_val_cnt - CNT_W'(1);
    assign min_cnt_m1 = r_min_cnt - CNT_W'(1);
    assign min_cnt_m2 = r_min_cnt - CNT_W'(2);
    assign stack_full = (r_val_cnt == CNT_W'(STACK_DEPTH));

    // a push goes onto the minimum stack when that stack is empty or the word
    // is at most its top
    assign min_push = ((r_min_cnt == '0) || ($signed(r_word) <= $signed(i_min_rdata)))
                      && (r_min_cnt < CNT_W'(STACK_DEPTH));

    // sequencer and result build
    always_comb begin
        n_state   = r_state;
        n_val_cnt = r_val_cnt;
        n_min_cnt = r_min_cnt;
        n_kind    = r_kind;
        n_word    = r_word;
        n_popped  = r_popped;
        o_val_req = '0;
        o_min_req = '0;
        o_res     = '0;
        o_res.status = ST_OK;

        case (r_state)
            S_IDLE: begin
                // fetch both tops for the new transaction
                if (accept) begin
                    n_kind          = i_in.kind;
                    n_word          = i_in.push_value;
                    o_val_req.re    = 1'b1;
                    o_val_req.raddr = val_cnt_m1[IDX_W-1:0];
                    o_min_req.re    = 1'b1;
                    o_min_req.raddr = min_cnt_m1[IDX_W-1:0];
                    n_state         = S_EXEC;
                end
            end

            S_EXEC: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                    if (r_kind == KIND_PUSH) begin
                        if (stack_full) begin
                            // overflow: report the unchanged stack
                            o_res.valid     = 1'b1;
                            o_res.status    = ST_OVERFLOW;
                            o_res.min_valid = (r_val_cnt != '0) && (r_min_cnt != '0);
                            o_res.cur_min   = o_res.min_valid ? i_min_rdata : '0;
                            o_res.depth     = r_val_cnt;
                        end else begin
                            o_val_req.we    = 1'b1;
                            o_val_req.waddr = r_val_cnt[IDX_W-1:0];
                            o_val_req.wdata = r_word;
                            n_val_cnt       = r_val_cnt + CNT_W'(1);
                            if (min_push) begin
                                o_min_req.we    = 1'b1;
                                o_min_req.waddr = r_min_cnt[IDX_W-1:0];
                                o_min_req.wdata = r_word;
                                n_min_cnt       = r_min_cnt + CNT_W'(1);
                            end
                            o_res.valid     = 1'b1;
                            o_res.min_valid = (n_min_cnt != '0);
                            o_res.cur_min   = !o_res.min_valid ? '0 :
                                              (min_push ? r_word : i_min_rdata);
                            o_res.depth     = n_val_cnt;
                        end
                    end else if (r_val_cnt == '0) begin
                        // underflow: popped value, minimum and depth read zero
                        o_res.valid  = 1'b1;
                        o_res.status = ST_UNDERFLOW;
                        o_res.depth  = r_val_cnt;
                    end else begin
                        n_val_cnt = val_cnt_m1;
                        n_popped  = i_val_rdata;
                        if ((r_min_cnt != '0) && (i_min_rdata == i_val_rdata)) begin
                            n_min_cnt = min_cnt_m1;
                        end
                        if ((n_min_cnt != r_min_cnt) && (n_min_cnt != '0)
                            && (n_val_cnt != '0)) begin
                            // minimum left with the word: fetch the one below
                            o_min_req.re    = 1'b1;
                            o_min_req.raddr = min_cnt_m2[IDX_W-1:0];
                            n_state         = S_FIX;
                        end else begin
                            o_res.valid     = 1'b1;
                            o_res.popped    = i_val_rdata;
                            o_res.min_valid = (n_val_cnt != '0) && (n_min_cnt != '0);
                            o_res.cur_min   = o_res.min_valid ? i_min_rdata : '0;
                            o_res.depth     = n_val_cnt;
                        end
                    end
                end
            end

            S_FIX: begin
                // output stage was free in the previous cycle and stays so
                o_res.valid     = 1'b1;
                o_res.popped    = r_popped;
                o_res.cur_min   = i_min_rdata;
                o_res.min_valid = 1'b1;
                o_res.depth     = r_val_cnt;
                n_state         = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_val_cnt <= '0;
            r_min_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_val_cnt <= n_val_cnt;
            r_min_cnt <= n_min_cnt;
        end
        r_kind   <= n_kind;
        r_word   <= n_word;
        r_popped <= n_popped;
    end

    // checks
    `MTS_ASSERT_IMPLIES(a_min_le_val, i_clk, i_rst_n, 1'b1, r_min_cnt <= r_val_cnt)
    `MTS_ASSERT_IMPLIES(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_val_cnt <= CNT_W'(STACK_DEPTH))
    `MTS_ASSERT_IMPLIES(a_res_room, i_clk, i_rst_n, o_res.valid, i_out_free)
    `MTS_ASSERT_NEXT(a_accept_exec, i_clk, i_rst_n, accept, r_state == S_EXEC)

endmodule

`default_nettype wire

// File: src/min_tracking_stack_core.sv
// ----------------------------------------------------------------------------
// min tracking stack core
// Stack of signed words that reports its current minimum with every result.
// ----------------------------------------------------------------------------
// Each push or pop returns one result. A request is accepted in S_IDLE and
// executed in S_EXEC once the output register is free to take its result.
// A pop that removes the current minimum while the stack stays non-empty
// passes through S_FIX to fetch the next minimum. The value and minimum
// stacks live in synchronous memories with registered read data, read in
// the accept cycle. The result is written to the output register from
// S_EXEC, or from S_FIX for such a pop. Only one transaction is in flight;
// a new request is taken while a result waits in the output register, but
// its execution stalls until that register drains. No clearing pass is
// needed after reset.
`timescale 1ns / 1ps
`default_nettype none

module min_tracking_stack_core import mts_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mts_in_if.sink    i_in,
    mts_out_if.source o_out
);

    t_mem_req          val_req;
    t_mem_req          min_req;
    t_result           res;
    logic [WORD_W-1:0] val_rdata;
    logic [WORD_W-1:0] min_rdata;
    logic              out_free;

    logic              r_out_valid;
    t_result           r_out;

    // value stack storage
    mts_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_req.we),
        .i_waddr (val_req.waddr),
        .i_wdata (val_req.wdata),
        .i_re    (val_req.re),
        .i_raddr (val_req.raddr),
        .o_rdata (val_rdata)
    );

    // minimum stack storage
    mts_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_min_ram (
        .i_clk   (i_clk),
        .i_we    (min_req.we),
        .i_waddr (min_req.waddr),
        .i_wdata (min_req.wdata),
        .i_re    (min_req.re),
        .i_raddr (min_req.raddr),
        .o_rdata (min_rdata)
    );

    mts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_val_rdata (val_rdata),
        .i_min_rdata (min_rdata),
        .i_out_free  (out_free),
        .o_val_req   (val_req),
        .o_min_req   (min_req),
        .o_res       (res)
    );

    // output register
    assign out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (res.valid) begin
            r_out <= res;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out.status;
    assign o_out.popped_value = r_out.popped;
    assign o_out.current_min  = r_out.cur_min;
    assign o_out.min_valid    = r_out.min_valid;
    assign o_out.depth        = r_out.depth;

endmodule

`default_nettype wire
